@@ rtl/rimr_pkg.sv @@
package rimr_pkg;

    // Build-time sizing
    localparam int CHANNELS         = 2;
    localparam int TICKS_PER_SECOND = 1000;
    localparam int CH_W             = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int MS_W             = 10;

    // Holding register map above the per-channel debounce registers
    localparam int H_BAUD   = CHANNELS + 0;
    localparam int H_PARITY = CHANNELS + 1;
    localparam int H_STOP   = CHANNELS + 2;
    localparam int H_REBOOT = CHANNELS + 3;
    localparam int H_ADDR   = CHANNELS + 4;

    // Limits and reset values
    localparam int DEBOUNCE_MAX = 100;
    localparam int ADDR_MAX     = 247;
    localparam logic [6:0]  DEBOUNCE_RESET = 7'd50;
    localparam logic [10:0] BAUD_RESET     = 11'd96;
    localparam logic [1:0]  PARITY_RESET   = 2'd0;
    localparam logic [1:0]  STOP_RESET     = 2'd2;
    localparam logic [7:0]  ADDR_RESET     = 8'd1;

    typedef enum logic [2:0] {
        CMD_TICK       = 3'd0,
        CMD_EDGE       = 3'd1,
        CMD_COIL_WRITE = 3'd2,
        CMD_COIL_READ  = 3'd3,
        CMD_DISC_READ  = 3'd4,
        CMD_INPUT_READ = 3'd5,
        CMD_HOLD_READ  = 3'd6,
        CMD_HOLD_WRITE = 3'd7
    } cmd_t;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_BAD_ADDR  = 2'd1,
        STATUS_BAD_VALUE = 2'd2
    } status_t;

    typedef struct packed {
        cmd_t        command;
        logic        channel;
        logic [2:0]  reg_index;
        logic [15:0] write_value;
    } item_t;

    typedef struct packed {
        status_t     status;
        logic [15:0] read_data;
        logic [1:0]  relay_levels;
        logic        reboot_request;
        logic        serial_changed;
        logic [10:0] baud_hundreds;
        logic [1:0]  parity_mode;
        logic [1:0]  stop_bit_count;
        logic [7:0]  slave_address;
    } result_t;

endpackage

@@ rtl/rimr_core.sv @@
module rimr_core (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              apply,
    input  rimr_pkg::item_t   item,
    output rimr_pkg::result_t result
);

    logic                  relay_reg    [rimr_pkg::CHANNELS];
    logic                  relay_next   [rimr_pkg::CHANNELS];
    logic                  level_reg    [rimr_pkg::CHANNELS];
    logic                  level_next   [rimr_pkg::CHANNELS];
    logic [15:0]           press_reg    [rimr_pkg::CHANNELS];
    logic [15:0]           press_next   [rimr_pkg::CHANNELS];
    logic [6:0]            debounce_reg [rimr_pkg::CHANNELS];
    logic [6:0]            debounce_next[rimr_pkg::CHANNELS];
    logic [6:0]            holdoff_reg  [rimr_pkg::CHANNELS];
    logic [6:0]            holdoff_next [rimr_pkg::CHANNELS];
    logic [rimr_pkg::MS_W-1:0] ms_reg, ms_next;
    logic [31:0]           uptime_reg, uptime_next;
    logic [10:0]           baud_reg, baud_next;
    logic [1:0]            parity_reg, parity_next;
    logic [1:0]            stop_reg, stop_next;
    logic [7:0]            addr_reg, addr_next;
    logic                  reboot_reg, reboot_next;

    logic [rimr_pkg::MS_W:0]   ms_inc;
    logic [rimr_pkg::CH_W-1:0] reg_ch;
    logic [rimr_pkg::CH_W-1:0] edge_ch;
    logic [rimr_pkg::CH_W-1:0] press_ch;
    logic [2:0]                press_off;
    logic                      baud_ok;
    rimr_pkg::status_t         status;
    logic [15:0]               data;
    logic                      changed;
    logic [1:0]                levels;

    assign reg_ch    = item.reg_index[rimr_pkg::CH_W-1:0];
    assign edge_ch   = rimr_pkg::CH_W'(item.channel);
    assign press_off = item.reg_index - 3'd2;
    assign press_ch  = press_off[rimr_pkg::CH_W-1:0];
    assign ms_inc    = {1'b0, ms_reg} + {{rimr_pkg::MS_W{1'b0}}, 1'b1};
    assign baud_ok   = item.write_value inside {16'd12, 16'd24, 16'd48, 16'd96,
                                                16'd192, 16'd384, 16'd576, 16'd1152};

    // Decode the command and form the next state and the result
    always_comb begin
        relay_next    = relay_reg;
        level_next    = level_reg;
        press_next    = press_reg;
        debounce_next = debounce_reg;
        holdoff_next  = holdoff_reg;
        ms_next       = ms_reg;
        uptime_next   = uptime_reg;
        baud_next     = baud_reg;
        parity_next   = parity_reg;
        stop_next     = stop_reg;
        addr_next     = addr_reg;
        reboot_next   = reboot_reg;
        status        = rimr_pkg::STATUS_OK;
        data          = 16'd0;
        changed       = 1'b0;

        case (item.command)
            rimr_pkg::CMD_TICK: begin
                for (int n = 0; n < rimr_pkg::CHANNELS; n++) begin
                    if (holdoff_reg[n] != 7'd0) begin
                        holdoff_next[n] = holdoff_reg[n] - 7'd1;
                    end
                end
                if (ms_inc >= (rimr_pkg::MS_W+1)'(rimr_pkg::TICKS_PER_SECOND)) begin
                    ms_next     = '0;
                    uptime_next = uptime_reg + 32'd1;
                end else begin
                    ms_next = ms_inc[rimr_pkg::MS_W-1:0];
                end
            end
            rimr_pkg::CMD_EDGE: begin
                if (int'(item.channel) >= rimr_pkg::CHANNELS) begin
                    status = rimr_pkg::STATUS_BAD_ADDR;
                end else begin
                    level_next[edge_ch] = ~level_reg[edge_ch];
                    if (!level_reg[edge_ch]) begin
                        // rising level: count a press once hold-off has expired
                        if (holdoff_reg[edge_ch] == 7'd0) begin
                            press_next[edge_ch] = press_reg[edge_ch] + 16'd1;
                            relay_next[edge_ch] = ~relay_reg[edge_ch];
                        end
                    end else begin
                        holdoff_next[edge_ch] = debounce_reg[edge_ch];
                    end
                end
            end
            rimr_pkg::CMD_COIL_WRITE: begin
                if (int'(item.reg_index) < rimr_pkg::CHANNELS) begin
                    relay_next[reg_ch] = item.write_value[0];
                end else begin
                    status = rimr_pkg::STATUS_BAD_ADDR;
                end
            end
            rimr_pkg::CMD_COIL_READ: begin
                if (int'(item.reg_index) < rimr_pkg::CHANNELS) begin
                    data = {15'd0, relay_reg[reg_ch]};
                end else begin
                    status = rimr_pkg::STATUS_BAD_ADDR;
                end
            end
            rimr_pkg::CMD_DISC_READ: begin
                if (int'(item.reg_index) < rimr_pkg::CHANNELS) begin
                    data = {15'd0, level_reg[reg_ch]};
                end else begin
                    status = rimr_pkg::STATUS_BAD_ADDR;
                end
            end
            rimr_pkg::CMD_INPUT_READ: begin
                if (item.reg_index == 3'd0) begin
                    data = uptime_reg[31:16];
                end else if (item.reg_index == 3'd1) begin
                    data = uptime_reg[15:0];
                end else if (int'(item.reg_index) - 2 < rimr_pkg::CHANNELS) begin
                    data = press_reg[press_ch];
                end else begin
                    status = rimr_pkg::STATUS_BAD_ADDR;
                end
            end
            rimr_pkg::CMD_HOLD_READ: begin
                if (int'(item.reg_index) < rimr_pkg::CHANNELS) begin
                    data = {9'd0, debounce_reg[reg_ch]};
                end else if (int'(item.reg_index) == rimr_pkg::H_BAUD) begin
                    data = {5'd0, baud_reg};
                end else if (int'(item.reg_index) == rimr_pkg::H_PARITY) begin
                    data = {14'd0, parity_reg};
                end else if (int'(item.reg_index) == rimr_pkg::H_STOP) begin
                    data = {14'd0, stop_reg};
                end else if (int'(item.reg_index) == rimr_pkg::H_ADDR) begin
                    data = {8'd0, addr_reg};
                end else begin
                    // reboot register is write only
                    status = rimr_pkg::STATUS_BAD_ADDR;
                end
            end
            rimr_pkg::CMD_HOLD_WRITE: begin
                if (int'(item.reg_index) < rimr_pkg::CHANNELS) begin
                    if (int'(item.write_value) > rimr_pkg::DEBOUNCE_MAX) begin
                        status = rimr_pkg::STATUS_BAD_VALUE;
                    end else begin
                        debounce_next[reg_ch] = item.write_value[6:0];
                    end
                end else if (int'(item.reg_index) == rimr_pkg::H_BAUD) begin
                    if (!baud_ok) begin
                        status = rimr_pkg::STATUS_BAD_VALUE;
                    end else if (item.write_value[10:0] != baud_reg) begin
                        baud_next = item.write_value[10:0];
                        changed   = 1'b1;
                    end
                end else if (int'(item.reg_index) == rimr_pkg::H_PARITY) begin
                    if (item.write_value > 16'd2) begin
                        status = rimr_pkg::STATUS_BAD_VALUE;
                    end else if (item.write_value[1:0] != parity_reg) begin
                        parity_next = item.write_value[1:0];
                        changed     = 1'b1;
                    end
                end else if (int'(item.reg_index) == rimr_pkg::H_STOP) begin
                    if (item.write_value < 16'd1 || item.write_value > 16'd2) begin
                        status = rimr_pkg::STATUS_BAD_VALUE;
                    end else if (item.write_value[1:0] != stop_reg) begin
                        stop_next = item.write_value[1:0];
                        changed   = 1'b1;
                    end
                end else if (int'(item.reg_index) == rimr_pkg::H_REBOOT) begin
                    reboot_next = (item.write_value != 16'd0);
                end else if (int'(item.reg_index) == rimr_pkg::H_ADDR) begin
                    if (item.write_value < 16'd1 ||
                        int'(item.write_value) > rimr_pkg::ADDR_MAX) begin
                        status = rimr_pkg::STATUS_BAD_VALUE;
                    end else begin
                        addr_next = item.write_value[7:0];
                    end
                end else begin
                    status = rimr_pkg::STATUS_BAD_ADDR;
                end
            end
            default: begin
                status = rimr_pkg::STATUS_BAD_ADDR;
            end
        endcase

        if (status != rimr_pkg::STATUS_OK) begin
            data = 16'd0;
        end
    end

    // Pack relay levels of the first two channels
    always_comb begin
        levels = 2'b00;
        for (int n = 0; n < 2; n++) begin
            if (n < rimr_pkg::CHANNELS) begin
                levels[n] = relay_next[n];
            end
        end
    end

    assign result.status         = status;
    assign result.read_data      = data;
    assign result.relay_levels   = levels;
    assign result.reboot_request = reboot_next;
    assign result.serial_changed = changed;
    assign result.baud_hundreds  = baud_next;
    assign result.parity_mode    = parity_next;
    assign result.stop_bit_count = stop_next;
    assign result.slave_address  = addr_next;

    // Commit the state on each transfer into the result stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int n = 0; n < rimr_pkg::CHANNELS; n++) begin
                relay_reg[n]    <= 1'b0;
                level_reg[n]    <= 1'b0;
                press_reg[n]    <= 16'd0;
                debounce_reg[n] <= rimr_pkg::DEBOUNCE_RESET;
                holdoff_reg[n]  <= 7'd0;
            end
            ms_reg     <= '0;
            uptime_reg <= 32'd0;
            baud_reg   <= rimr_pkg::BAUD_RESET;
            parity_reg <= rimr_pkg::PARITY_RESET;
            stop_reg   <= rimr_pkg::STOP_RESET;
            addr_reg   <= rimr_pkg::ADDR_RESET;
            reboot_reg <= 1'b0;
        end else if (apply) begin
            relay_reg    <= relay_next;
            level_reg    <= level_next;
            press_reg    <= press_next;
            debounce_reg <= debounce_next;
            holdoff_reg  <= holdoff_next;
            ms_reg       <= ms_next;
            uptime_reg   <= uptime_next;
            baud_reg     <= baud_next;
            parity_reg   <= parity_next;
            stop_reg     <= stop_next;
            addr_reg     <= addr_next;
            reboot_reg   <= reboot_next;
        end
    end

    // Settings and the millisecond count stay inside their legal ranges; state holds without a transfer
    a_stop_range: assert property (@(posedge aclk) disable iff (!aresetn)
        stop_reg == 2'd1 || stop_reg == 2'd2)
        else $error("stop bit setting out of range");

    a_addr_range: assert property (@(posedge aclk) disable iff (!aresetn)
        addr_reg != 8'd0 && int'(addr_reg) <= rimr_pkg::ADDR_MAX)
        else $error("slave address out of range");

    a_ms_range: assert property (@(posedge aclk) disable iff (!aresetn)
        int'(ms_reg) < rimr_pkg::TICKS_PER_SECOND)
        else $error("millisecond count past one second");

    a_hold_state: assert property (@(posedge aclk) disable iff (!aresetn)
        !apply |=> $stable(uptime_reg) && $stable(baud_reg) && $stable(reboot_reg))
        else $error("state changed without a transfer");

endmodule

@@ rtl/relay_input_module_registers.sv @@
// Relay and input module register map.
// Input channel s_*: one command per transfer (tick, pin edge, coil, discrete,
// input or holding register access). Result channel m_*: exactly one result
// per command, carrying the status, read data and the current relay levels,
// reboot flag and serial/address settings as they stand after the command.
// Path: a command accepted on s_* is held in the input register, moves into the
// result register when that stage is free or m_ready is high, and shows on m_*
// from there; the state is committed at the same edge as that result transfer.
// Throughput: one command per cycle while m_ready stays high; the decode and
// update path between the input register and the result register is combinational.
// Stall: while m_ready is low the result register holds and one more command
// waits in the input register; s_ready drops only once both are occupied.
// Reset: aresetn low (synchronous) empties both registers and returns relays,
// counters, timers and settings to their defaults (debounce 50 ms, 9600 baud,
// no parity, 2 stop bits, address 1).
module relay_input_module_registers (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_command,
    input  logic        s_channel,
    input  logic [2:0]  s_reg_index,
    input  logic [15:0] s_write_value,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [15:0] m_read_data,
    output logic [1:0]  m_relay_levels,
    output logic        m_reboot_request,
    output logic        m_serial_changed,
    output logic [10:0] m_baud_hundreds,
    output logic [1:0]  m_parity_mode,
    output logic [1:0]  m_stop_bit_count,
    output logic [7:0]  m_slave_address
);

    logic              in_valid_reg;
    rimr_pkg::item_t   item_reg;
    logic              out_valid_reg;
    rimr_pkg::result_t result_reg;
    rimr_pkg::result_t result_next;
    logic              advance;
    logic              take;

    // Move the held command on when the result stage is free or draining
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign take    = s_valid && s_ready;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (take) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            item_reg.command     <= rimr_pkg::cmd_t'(s_command);
            item_reg.channel     <= s_channel;
            item_reg.reg_index   <= s_reg_index;
            item_reg.write_value <= s_write_value;
        end
    end

    rimr_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .apply   (advance),
        .item    (item_reg),
        .result  (result_next)
    );

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            result_reg <= result_next;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_status         = result_reg.status;
    assign m_read_data      = result_reg.read_data;
    assign m_relay_levels   = result_reg.relay_levels;
    assign m_reboot_request = result_reg.reboot_request;
    assign m_serial_changed = result_reg.serial_changed;
    assign m_baud_hundreds  = result_reg.baud_hundreds;
    assign m_parity_mode    = result_reg.parity_mode;
    assign m_stop_bit_count = result_reg.stop_bit_count;
    assign m_slave_address  = result_reg.slave_address;

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && !in_valid_reg)
        else $error("pipeline not empty after reset");

    a_advance_fills: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_valid)
        else $error("transfer into result stage lost");

    a_wait_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !advance |=> in_valid_reg && $stable(item_reg))
        else $error("held command dropped or changed");

    a_error_no_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != rimr_pkg::STATUS_OK |-> m_read_data == 16'd0)
        else $error("read data on a failed access");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_status != 2'd3)
        else $error("undefined status code");

endmodule

@@ bench/relay_map_checker.sv @@
`timescale 1ns / 1ps

module relay_map_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [2:0]  s_command,
    input  logic        s_channel,
    input  logic [2:0]  s_reg_index,
    input  logic [15:0] s_write_value,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [1:0]  m_status,
    input  logic [15:0] m_read_data,
    input  logic [1:0]  m_relay_levels,
    input  logic        m_reboot_request,
    input  logic        m_serial_changed,
    input  logic [10:0] m_baud_hundreds,
    input  logic [1:0]  m_parity_mode,
    input  logic [1:0]  m_stop_bit_count,
    input  logic [7:0]  m_slave_address,
    output int          mismatches,
    output int          pending
);

    // Shadow copy of the module state
    logic        relay_on  [rimr_pkg::CHANNELS];
    logic        pin_level [rimr_pkg::CHANNELS];
    logic [15:0] presses   [rimr_pkg::CHANNELS];
    logic [6:0]  debounce  [rimr_pkg::CHANNELS];
    logic [6:0]  holdoff   [rimr_pkg::CHANNELS];
    logic [9:0]  ms_count;
    logic [31:0] uptime;
    logic [10:0] baud;
    logic [1:0]  parity;
    logic [1:0]  stop_count;
    logic [7:0]  bus_addr;
    logic        reboot;

    rimr_pkg::result_t expected_replies[$];
    rimr_pkg::item_t   cmd;
    rimr_pkg::result_t got;
    rimr_pkg::result_t want;
    int      replies_seen;
    int      n;

    initial begin
        mismatches = 0;
        pending = 0;
        replies_seen = 0;
    end

    // Apply one command to the shadow state and return the reply it produces
    function automatic rimr_pkg::result_t apply_command(input rimr_pkg::item_t it);
        rimr_pkg::result_t r;
        logic [15:0] v;
        int unsigned idx;
        logic        ch;
        logic        baud_legal;
        int          k;
        r = '0;
        r.status = rimr_pkg::STATUS_OK;
        v = it.write_value;
        idx = 32'(it.reg_index);
        ch = it.channel;
        case (it.command)
            rimr_pkg::CMD_TICK: begin
                for (k = 0; k < rimr_pkg::CHANNELS; k++)
                    if (holdoff[k] != 0) holdoff[k] = holdoff[k] - 1'b1;
                // roll the millisecond count into the uptime
                if (ms_count == rimr_pkg::TICKS_PER_SECOND - 1) begin
                    ms_count = '0;
                    uptime = uptime + 1'b1;
                end else begin
                    ms_count = ms_count + 1'b1;
                end
            end
            rimr_pkg::CMD_EDGE: begin
                if (ch >= rimr_pkg::CHANNELS) begin
                    r.status = rimr_pkg::STATUS_BAD_ADDR;
                end else begin
                    pin_level[ch] = ~pin_level[ch];
                    // count a press only once the hold-off has run out
                    if (pin_level[ch]) begin
                        if (holdoff[ch] == 0) begin
                            presses[ch] = presses[ch] + 1'b1;
                            relay_on[ch] = ~relay_on[ch];
                        end
                    end else begin
                        holdoff[ch] = debounce[ch];
                    end
                end
            end
            rimr_pkg::CMD_COIL_WRITE: begin
                if (idx < rimr_pkg::CHANNELS) relay_on[idx] = v[0];
                else r.status = rimr_pkg::STATUS_BAD_ADDR;
            end
            rimr_pkg::CMD_COIL_READ: begin
                if (idx < rimr_pkg::CHANNELS) r.read_data = 16'(relay_on[idx]);
                else r.status = rimr_pkg::STATUS_BAD_ADDR;
            end
            rimr_pkg::CMD_DISC_READ: begin
                if (idx < rimr_pkg::CHANNELS) r.read_data = 16'(pin_level[idx]);
                else r.status = rimr_pkg::STATUS_BAD_ADDR;
            end
            rimr_pkg::CMD_INPUT_READ: begin
                if (idx == 0) r.read_data = uptime[31:16];
                else if (idx == 1) r.read_data = uptime[15:0];
                else if (idx < 2 + rimr_pkg::CHANNELS) r.read_data = presses[idx - 2];
                else r.status = rimr_pkg::STATUS_BAD_ADDR;
            end
            rimr_pkg::CMD_HOLD_READ: begin
                if (idx < rimr_pkg::CHANNELS) r.read_data = 16'(debounce[idx]);
                else if (idx == rimr_pkg::H_BAUD) r.read_data = 16'(baud);
                else if (idx == rimr_pkg::H_PARITY) r.read_data = 16'(parity);
                else if (idx == rimr_pkg::H_STOP) r.read_data = 16'(stop_count);
                else if (idx == rimr_pkg::H_ADDR) r.read_data = 16'(bus_addr);
                else r.status = rimr_pkg::STATUS_BAD_ADDR;
            end
            default: begin
                // holding write: validate the range, then update
                if (idx < rimr_pkg::CHANNELS) begin
                    if (v > rimr_pkg::DEBOUNCE_MAX) r.status = rimr_pkg::STATUS_BAD_VALUE;
                    else debounce[idx] = v[6:0];
                end else if (idx == rimr_pkg::H_BAUD) begin
                    case (v)
                        16'd12, 16'd24, 16'd48, 16'd96,
                        16'd192, 16'd384, 16'd576, 16'd1152: baud_legal = 1'b1;
                        default: baud_legal = 1'b0;
                    endcase
                    if (!baud_legal) begin
                        r.status = rimr_pkg::STATUS_BAD_VALUE;
                    end else if (v != baud) begin
                        baud = v[10:0];
                        r.serial_changed = 1'b1;
                    end
                end else if (idx == rimr_pkg::H_PARITY) begin
                    if (v > 2) begin
                        r.status = rimr_pkg::STATUS_BAD_VALUE;
                    end else if (v != parity) begin
                        parity = v[1:0];
                        r.serial_changed = 1'b1;
                    end
                end else if (idx == rimr_pkg::H_STOP) begin
                    if (v < 1 || v > 2) begin
                        r.status = rimr_pkg::STATUS_BAD_VALUE;
                    end else if (v != stop_count) begin
                        stop_count = v[1:0];
                        r.serial_changed = 1'b1;
                    end
                end else if (idx == rimr_pkg::H_REBOOT) begin
                    reboot = (v != 0);
                end else if (idx == rimr_pkg::H_ADDR) begin
                    if (v < 1 || v > rimr_pkg::ADDR_MAX) r.status = rimr_pkg::STATUS_BAD_VALUE;
                    else bus_addr = v[7:0];
                end else begin
                    r.status = rimr_pkg::STATUS_BAD_ADDR;
                end
            end
        endcase
        if (r.status != rimr_pkg::STATUS_OK) r.read_data = '0;

        for (k = 0; k < rimr_pkg::CHANNELS && k < 2; k++)
            r.relay_levels[k] = relay_on[k];
        r.reboot_request = reboot;
        r.baud_hundreds = baud;
        r.parity_mode = parity;
        r.stop_bit_count = stop_count;
        r.slave_address = bus_addr;
        return r;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            for (n = 0; n < rimr_pkg::CHANNELS; n++) begin
                relay_on[n] = 1'b0;
                pin_level[n] = 1'b0;
                presses[n] = '0;
                debounce[n] = rimr_pkg::DEBOUNCE_RESET;
                holdoff[n] = '0;
            end
            ms_count = '0;
            uptime = '0;
            baud = rimr_pkg::BAUD_RESET;
            parity = rimr_pkg::PARITY_RESET;
            stop_count = rimr_pkg::STOP_RESET;
            bus_addr = rimr_pkg::ADDR_RESET;
            reboot = 1'b0;
            expected_replies.delete();
            pending = 0;
        end else begin
            // predict the reply of every command transfer
            if (s_valid && s_ready) begin
                cmd = {s_command, s_channel, s_reg_index, s_write_value};
                expected_replies.push_back(apply_command(cmd));
            end

            // compare every result transfer with the oldest prediction
            if (m_valid && m_ready) begin
                replies_seen++;
                got = {m_status, m_read_data, m_relay_levels, m_reboot_request,
                       m_serial_changed, m_baud_hundreds, m_parity_mode,
                       m_stop_bit_count, m_slave_address};
                if (expected_replies.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result %0d arrived with no command outstanding",
                                 replies_seen);
                end else begin
                    want = expected_replies.pop_front();
                    if (got.status !== want.status ||
                        got.read_data !== want.read_data ||
                        got.relay_levels !== want.relay_levels ||
                        got.reboot_request !== want.reboot_request ||
                        got.serial_changed !== want.serial_changed ||
                        got.baud_hundreds !== want.baud_hundreds ||
                        got.parity_mode !== want.parity_mode ||
                        got.stop_bit_count !== want.stop_bit_count ||
                        got.slave_address !== want.slave_address) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"result %0d (expected/actual): status %0d/%0d ",
                                      "data %h/%h relays %b/%b reboot %b/%b ",
                                      "serial %b/%b baud %0d/%0d parity %0d/%0d ",
                                      "stop %0d/%0d addr %0d/%0d"},
                                     replies_seen, want.status, got.status,
                                     want.read_data, got.read_data,
                                     want.relay_levels, got.relay_levels,
                                     want.reboot_request, got.reboot_request,
                                     want.serial_changed, got.serial_changed,
                                     want.baud_hundreds, got.baud_hundreds,
                                     want.parity_mode, got.parity_mode,
                                     want.stop_bit_count, got.stop_bit_count,
                                     want.slave_address, got.slave_address);
                    end
                end
            end
            pending = expected_replies.size();
        end
    end

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int MIXED_ITEMS  = 1380;
    localparam int LONG_HOLD    = 64;
    localparam int DRAIN_CYCLES = 10;
    localparam int BURST_EDGES  = 48;
    localparam logic [15:0] BAUD_STEPS [8] = '{16'd12, 16'd24, 16'd48, 16'd96,
                                              16'd192, 16'd384, 16'd576, 16'd1152};

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [2:0]  s_command;
    logic        s_channel;
    logic [2:0]  s_reg_index;
    logic [15:0] s_write_value;
    logic        m_valid;
    logic        m_ready;
    logic [1:0]  m_status;
    logic [15:0] m_read_data;
    logic [1:0]  m_relay_levels;
    logic        m_reboot_request;
    logic        m_serial_changed;
    logic [10:0] m_baud_hundreds;
    logic [1:0]  m_parity_mode;
    logic [1:0]  m_stop_bit_count;
    logic [7:0]  m_slave_address;

    int mismatches;
    int pending;
    int sent;
    int cycle_count;
    bit idle_on;
    bit hold_request;

    relay_input_module_registers dut (.*);

    relay_map_checker checker_i (.*);

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Bound the run
    initial cycle_count = 0;
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Offer one command, entered and left at a falling edge
    task automatic send_item(input rimr_pkg::cmd_t c, input logic ch,
                             input logic [2:0] idx, input logic [15:0] val);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_valid = 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge aclk);
        end
        s_valid = 1'b1;
        s_command = c;
        s_channel = ch;
        s_reg_index = idx;
        s_write_value = val;
        do @(posedge aclk); while (!s_ready);
        sent++;
        @(negedge aclk);
    endtask

    // Result side: ready bursts, random stalls and one long hold-off
    initial begin
        m_ready = 1'b0;
        @(posedge aresetn);
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                m_ready = 1'b0;
                repeat (LONG_HOLD) @(negedge aclk);
            end else if (idle_on && $urandom_range(0, 4) == 0) begin
                m_ready = 1'b0;
                repeat ($urandom_range(1, 10)) @(negedge aclk);
            end else begin
                m_ready = 1'b1;
                repeat ($urandom_range(1, 20)) @(negedge aclk);
            end
        end
    end

    initial begin
        int          pick;
        bit          hold_done;
        logic        ch;
        logic [2:0]  idx;
        logic [15:0] val;

        aresetn = 1'b0;
        s_valid = 1'b0;
        s_command = rimr_pkg::CMD_TICK;
        s_channel = 1'b0;
        s_reg_index = '0;
        s_write_value = '0;
        sent = 0;
        idle_on = 1'b1;
        hold_request = 1'b0;
        hold_done = 1'b0;
        repeat (7) @(negedge aclk);
        aresetn = 1'b1;

        // Directed: reset values, limits, illegal addresses and values
        send_item(rimr_pkg::CMD_HOLD_READ, 1'b0, 3'(rimr_pkg::H_BAUD), 16'h0000);
        send_item(rimr_pkg::CMD_HOLD_READ, 1'b0, 3'(rimr_pkg::H_REBOOT), 16'hFFFF);
        send_item(rimr_pkg::CMD_HOLD_READ, 1'b1, 3'd7, 16'h0000);
        send_item(rimr_pkg::CMD_EDGE, 1'b0, 3'd0, 16'h0000);
        send_item(rimr_pkg::CMD_EDGE, 1'b0, 3'd0, 16'h0000);
        send_item(rimr_pkg::CMD_EDGE, 1'b0, 3'd0, 16'h0000);
        send_item(rimr_pkg::CMD_HOLD_WRITE, 1'b0, 3'd0, 16'(rimr_pkg::DEBOUNCE_MAX));
        send_item(rimr_pkg::CMD_HOLD_WRITE, 1'b0, 3'd1, 16'(rimr_pkg::DEBOUNCE_MAX + 1));
        send_item(rimr_pkg::CMD_HOLD_WRITE, 1'b0, 3'(rimr_pkg::H_BAUD), 16'd1152);
        send_item(rimr_pkg::CMD_HOLD_WRITE, 1'b0, 3'(rimr_pkg::H_BAUD), 16'd1152);
        send_item(rimr_pkg::CMD_HOLD_WRITE, 1'b0, 3'(rimr_pkg::H_BAUD), 16'd100);
        send_item(rimr_pkg::CMD_HOLD_WRITE, 1'b0, 3'(rimr_pkg::H_STOP), 16'd0);
        send_item(rimr_pkg::CMD_HOLD_WRITE, 1'b0, 3'(rimr_pkg::H_PARITY), 16'd2);
        send_item(rimr_pkg::CMD_HOLD_WRITE, 1'b0, 3'(rimr_pkg::H_ADDR),
                  16'(rimr_pkg::ADDR_MAX));
        send_item(rimr_pkg::CMD_HOLD_WRITE, 1'b0, 3'(rimr_pkg::H_ADDR),
                  16'(rimr_pkg::ADDR_MAX + 1));
        send_item(rimr_pkg::CMD_HOLD_WRITE, 1'b0, 3'(rimr_pkg::H_ADDR), 16'd0);
        send_item(rimr_pkg::CMD_HOLD_WRITE, 1'b0, 3'(rimr_pkg::H_REBOOT), 16'hFFFF);
        send_item(rimr_pkg::CMD_COIL_WRITE, 1'b0, 3'd0, 16'hFFFF);
        send_item(rimr_pkg::CMD_COIL_WRITE, 1'b0, 3'd2, 16'h0001);
        send_item(rimr_pkg::CMD_COIL_READ, 1'b0, 3'd1, 16'h0000);
        send_item(rimr_pkg::CMD_DISC_READ, 1'b0, 3'd0, 16'h0000);
        send_item(rimr_pkg::CMD_TICK, 1'b1, 3'd7, 16'hFFFF);
        send_item(rimr_pkg::CMD_INPUT_READ, 1'b0, 3'd2, 16'h0000);
        send_item(rimr_pkg::CMD_INPUT_READ, 1'b0, 3'd0, 16'h0000);
        send_item(rimr_pkg::CMD_INPUT_READ, 1'b0, 3'd6, 16'h0000);

        // Mixed traffic: press sequences, tick runs and register accesses
        while (sent < MIXED_ITEMS) begin
            idle_on = !(sent >= 600 && sent < 800);
            if (sent >= 300 && !hold_done) begin
                hold_request = 1'b1;
                hold_done = 1'b1;
            end
            pick = $urandom_range(0, 99);
            ch = 1'($urandom_range(0, 1));
            idx = 3'($urandom_range(0, 7));
            val = 16'($urandom_range(0, 65535));
            if (pick < 8) begin
                repeat ($urandom_range(20, 120))
                    send_item(rimr_pkg::CMD_TICK, ch, idx, val);
            end else if (pick < 35) begin
                // press and release with zero to four tick commands between
                send_item(rimr_pkg::CMD_EDGE, ch, idx, val);
                repeat ($urandom_range(0, 4)) send_item(rimr_pkg::CMD_TICK, ch, idx, val);
                send_item(rimr_pkg::CMD_EDGE, ch, idx, val);
                if ($urandom_range(0, 1))
                    send_item(rimr_pkg::CMD_INPUT_READ, ch, {2'b01, ch}, val);
            end else if (pick < 50) begin
                send_item(rimr_pkg::CMD_TICK, ch, idx, val);
            end else if (pick < 55) begin
                send_item(rimr_pkg::CMD_EDGE, ch, idx, val);
            end else if (pick < 62) begin
                if ($urandom_range(0, 1)) idx = {2'b00, ch};
                send_item(rimr_pkg::CMD_COIL_WRITE, ch, idx, val);
            end else if (pick < 70) begin
                send_item(pick < 66 ? rimr_pkg::CMD_COIL_READ : rimr_pkg::CMD_DISC_READ,
                          ch, idx, val);
            end else if (pick < 78) begin
                send_item(rimr_pkg::CMD_INPUT_READ, ch, idx, val);
            end else if (pick < 86) begin
                send_item(rimr_pkg::CMD_HOLD_READ, ch, idx, val);
            end else begin
                // mostly legal values, the rest raw noise
                if ($urandom_range(0, 3) != 0) begin
                    if (idx < rimr_pkg::CHANNELS)
                        val = $urandom_range(0, 3) ? 16'($urandom_range(0, 10))
                                : 16'($urandom_range(0, rimr_pkg::DEBOUNCE_MAX));
                    else if (idx == rimr_pkg::H_BAUD)
                        val = BAUD_STEPS[$urandom_range(0, 7)];
                    else if (idx == rimr_pkg::H_PARITY)
                        val = 16'($urandom_range(0, 2));
                    else if (idx == rimr_pkg::H_STOP)
                        val = 16'($urandom_range(1, 2));
                    else if (idx == rimr_pkg::H_REBOOT)
                        val = $urandom_range(0, 1) ? 16'd0 : val;
                    else if (idx == rimr_pkg::H_ADDR)
                        val = 16'($urandom_range(1, rimr_pkg::ADDR_MAX));
                end
                send_item(rimr_pkg::CMD_HOLD_WRITE, ch, idx, val);
            end
        end

        // Close with a burst of channel 1 presses at full rate
        idle_on = 1'b0;
        send_item(rimr_pkg::CMD_HOLD_WRITE, 1'b0, 3'd1, 16'd0);
        repeat (BURST_EDGES) send_item(rimr_pkg::CMD_EDGE, 1'b1, 3'd0, 16'h0000);
        send_item(rimr_pkg::CMD_INPUT_READ, 1'b0, 3'd3, 16'h0000);
        send_item(rimr_pkg::CMD_COIL_READ, 1'b0, 3'd1, 16'h0000);
        s_valid = 1'b0;

        // Drain, then watch for stray results
        while (pending != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

@@ files.f @@
rtl/rimr_pkg.sv
rtl/rimr_core.sv
rtl/relay_input_module_registers.sv
bench/relay_map_checker.sv
bench/tb_top.sv
